// File: rtl/core/nvbp_pkg.sv
// Shared phase codes, role codes and types for the name/value block parser.
package nvbp_pkg;

    localparam logic [3:0] PH_COUNT_HI = 4'd0;
    localparam logic [3:0] PH_COUNT_LO = 4'd1;
    localparam logic [3:0] PH_NLEN_HI  = 4'd2;
    localparam logic [3:0] PH_NLEN_LO  = 4'd3;
    localparam logic [3:0] PH_NAME     = 4'd4;
    localparam logic [3:0] PH_VLEN_HI  = 4'd5;
    localparam logic [3:0] PH_VLEN_LO  = 4'd6;
    localparam logic [3:0] PH_VALUE    = 4'd7;
    localparam logic [3:0] PH_DONE     = 4'd8;

    localparam logic [2:0] ROLE_COUNT = 3'd0;
    localparam logic [2:0] ROLE_NLEN  = 3'd1;
    localparam logic [2:0] ROLE_NAME  = 3'd2;
    localparam logic [2:0] ROLE_VLEN  = 3'd3;
    localparam logic [2:0] ROLE_VALUE = 3'd4;
    localparam logic [2:0] ROLE_TRAIL = 3'd5;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  high_byte_hold;
        logic [15:0] pair_total;
        logic [15:0] pairs_seen;
        logic [15:0] bytes_left;
    } state_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  role;
        logic [15:0] pair_index;
        logic        item_end;
        logic        block_done;
        logic        status;
    } result_t;

endpackage

// File: rtl/core/nvbp_if.sv
// Request channels of the name/value block parser: raw bytes in, tagged bytes out.
interface nvbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface nvbp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [2:0]  role;
    logic [15:0] pair_index;
    logic        item_end;
    logic        block_done;
    logic        status;

    modport source (output valid, output byte_out, output role, output pair_index,
                    output item_end, output block_done, output status, input ready);
    modport sink (input valid, input byte_out, input role, input pair_index,
                  input item_end, input block_done, input status, output ready);
endinterface

// File: rtl/core/nvbp_step.sv
// Per-byte parse step: next parser state and the tagged result for one byte.
module nvbp_step (
    input  nvbp_pkg::state_t  state,
    input  logic [7:0]        data_byte,
    input  logic              end_of_data,
    output nvbp_pkg::state_t  state_next,
    output nvbp_pkg::result_t result
);

    logic [15:0]      len;
    logic [15:0]      bytes_dec;
    logic [15:0]      seen_inc;
    logic             item_end;
    logic             done;
    nvbp_pkg::state_t stepped;

    assign len       = {state.high_byte_hold, data_byte};
    assign bytes_dec = state.bytes_left - 16'd1;
    assign seen_inc  = state.pairs_seen + 16'd1;

    always_comb
    begin
        stepped  = state;
        item_end = 1'b0;
        done     = 1'b0;
        result.role = nvbp_pkg::ROLE_TRAIL;
        case (state.phase)
            nvbp_pkg::PH_COUNT_HI:
            begin
                result.role            = nvbp_pkg::ROLE_COUNT;
                stepped.high_byte_hold = data_byte;
                stepped.phase          = nvbp_pkg::PH_COUNT_LO;
            end
            nvbp_pkg::PH_COUNT_LO:
            begin
                result.role        = nvbp_pkg::ROLE_COUNT;
                stepped.pair_total = len;
                stepped.pairs_seen = 16'd0;
                if (len == 16'd0)
                begin
                    done          = 1'b1;
                    stepped.phase = nvbp_pkg::PH_DONE;
                end
                else
                begin
                    stepped.phase = nvbp_pkg::PH_NLEN_HI;
                end
            end
            nvbp_pkg::PH_NLEN_HI:
            begin
                result.role            = nvbp_pkg::ROLE_NLEN;
                stepped.high_byte_hold = data_byte;
                stepped.phase          = nvbp_pkg::PH_NLEN_LO;
            end
            nvbp_pkg::PH_NLEN_LO:
            begin
                result.role = nvbp_pkg::ROLE_NLEN;
                if (len == 16'd0)
                begin
                    item_end      = 1'b1;
                    stepped.phase = nvbp_pkg::PH_VLEN_HI;
                end
                else
                begin
                    stepped.bytes_left = len;
                    stepped.phase      = nvbp_pkg::PH_NAME;
                end
            end
            nvbp_pkg::PH_NAME:
            begin
                result.role        = nvbp_pkg::ROLE_NAME;
                stepped.bytes_left = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    item_end      = 1'b1;
                    stepped.phase = nvbp_pkg::PH_VLEN_HI;
                end
            end
            nvbp_pkg::PH_VLEN_HI:
            begin
                result.role            = nvbp_pkg::ROLE_VLEN;
                stepped.high_byte_hold = data_byte;
                stepped.phase          = nvbp_pkg::PH_VLEN_LO;
            end
            nvbp_pkg::PH_VLEN_LO:
            begin
                result.role = nvbp_pkg::ROLE_VLEN;
                if (len == 16'd0)
                begin
                    // An empty value closes the pair on its length byte.
                    item_end           = 1'b1;
                    stepped.pairs_seen = seen_inc;
                    if (seen_inc == state.pair_total)
                    begin
                        done          = 1'b1;
                        stepped.phase = nvbp_pkg::PH_DONE;
                    end
                    else
                    begin
                        stepped.phase = nvbp_pkg::PH_NLEN_HI;
                    end
                end
                else
                begin
                    stepped.bytes_left = len;
                    stepped.phase      = nvbp_pkg::PH_VALUE;
                end
            end
            nvbp_pkg::PH_VALUE:
            begin
                result.role        = nvbp_pkg::ROLE_VALUE;
                stepped.bytes_left = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    item_end           = 1'b1;
                    stepped.pairs_seen = seen_inc;
                    if (seen_inc == state.pair_total)
                    begin
                        done          = 1'b1;
                        stepped.phase = nvbp_pkg::PH_DONE;
                    end
                    else
                    begin
                        stepped.phase = nvbp_pkg::PH_NLEN_HI;
                    end
                end
            end
            default:
            begin
                result.role   = nvbp_pkg::ROLE_TRAIL;
                stepped.phase = nvbp_pkg::PH_DONE;
            end
        endcase

        result.byte_out   = data_byte;
        result.pair_index = state.pairs_seen;
        result.item_end   = item_end;
        result.block_done = done;
        result.status     = end_of_data && (stepped.phase != nvbp_pkg::PH_DONE);

        if (end_of_data)
        begin
            state_next.phase          = nvbp_pkg::PH_COUNT_HI;
            state_next.high_byte_hold = 8'd0;
            state_next.pair_total     = 16'd0;
            state_next.pairs_seen     = 16'd0;
            state_next.bytes_left     = 16'd0;
        end
        else
        begin
            state_next = stepped;
        end
    end

endmodule

// File: rtl/core/name_value_block_parser.sv
// Top level of the name/value header block parser: state and result registers.
// The parser takes one byte per cycle when not stalled and gives one tagged result
// per byte, in the cycle after the byte is accepted. A single output register
// holds the result; a new byte is accepted whenever that register is empty or
// is being emptied in the same cycle, so a ready sink sustains one byte per clock.
// A byte with end_of_data set ends the buffer and the next byte starts a new block.
module name_value_block_parser (
    input  logic            clk,
    input  logic            rst_n,
    nvbp_in_if.sink         raw,
    nvbp_out_if.source      parsed
);

    nvbp_pkg::state_t  state_reg;
    nvbp_pkg::state_t  state_next;
    nvbp_pkg::result_t result_next;
    nvbp_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              in_fire;

    nvbp_step u_step (
        .state       (state_reg),
        .data_byte   (raw.data_byte),
        .end_of_data (raw.end_of_data),
        .state_next  (state_next),
        .result      (result_next)
    );

    assign raw.ready = !out_valid_reg || parsed.ready;
    assign in_fire   = raw.valid && raw.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= nvbp_pkg::PH_COUNT_HI;
            state_reg.high_byte_hold <= 8'd0;
            state_reg.pair_total     <= 16'd0;
            state_reg.pairs_seen     <= 16'd0;
            state_reg.bytes_left     <= 16'd0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (parsed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign parsed.valid      = out_valid_reg;
    assign parsed.byte_out   = result_reg.byte_out;
    assign parsed.role       = result_reg.role;
    assign parsed.pair_index = result_reg.pair_index;
    assign parsed.item_end   = result_reg.item_end;
    assign parsed.block_done = result_reg.block_done;
    assign parsed.status     = result_reg.status;

    // The end of a buffer always leaves the parser waiting for a new count.
    a_eod_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && raw.end_of_data |=> state_reg.phase == nvbp_pkg::PH_COUNT_HI)
        else $error("parser did not restart after end of buffer");

    // A finished block has seen exactly as many pairs as its count announced.
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == nvbp_pkg::PH_DONE |-> state_reg.pairs_seen == state_reg.pair_total)
        else $error("finished block with a pair count mismatch");

    // A completing byte never reports a short buffer.
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.block_done |-> !result_reg.status)
        else $error("block completion reported together with short data");

    // Only length and content bytes of a name or value can end one.
    a_item_end_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.item_end |->
            (result_reg.role == nvbp_pkg::ROLE_NLEN || result_reg.role == nvbp_pkg::ROLE_NAME
             || result_reg.role == nvbp_pkg::ROLE_VLEN
             || result_reg.role == nvbp_pkg::ROLE_VALUE))
        else $error("item end flagged on a count or trailing byte");

    // An empty result register never holds off the input.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> raw.ready)
        else $error("input stalled while the result register is empty");

endmodule
